[rtl/sfr_pkg.sv]
// sfr_pkg: shared constants, register indexes and the emit command type
// for the stream find-and-replace block. No dependencies.
package sfr_pkg;

  localparam int MAX_PATTERN_DEF     = 8;
  localparam int MAX_REPLACEMENT_DEF = 8;
  localparam int REG_CHARS           = 8;
  localparam int CMD_BYTES           = 8;
  localparam int CNT_W               = $clog2(CMD_BYTES + 1);
  localparam int IDX_W               = $clog2(CMD_BYTES);
  localparam int QUEUE_DEPTH         = 2;
  localparam int CFG_IDX_W           = 2;
  localparam int CFG_DATA_W          = 64;

  localparam logic [7:0] NEWLINE_CHAR = 8'h0A;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LENGTH,
    REG_PATTERN_BYTES,
    REG_REPLACEMENT_LENGTH,
    REG_REPLACEMENT_BYTES
  } cfg_reg_t;

  typedef logic [CMD_BYTES-1:0][7:0] byte_vec_t;

  // up to CMD_BYTES output bytes, lowest first, count of bytes in use
  typedef struct packed {
    byte_vec_t        bytes;
    logic [CNT_W-1:0] count;
  } emit_cmd_t;

endpackage

[rtl/sfr_front.sv]
// sfr_front: configuration registers, pending match window and per-byte
// classification into emit commands. Depends on sfr_pkg.
module sfr_front import sfr_pkg::*; #(
  parameter int MAX_PATTERN     = MAX_PATTERN_DEF,
  parameter int MAX_REPLACEMENT = MAX_REPLACEMENT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_data_byte,
  input  logic                  in_stream_end,
  input  logic                  q_full,
  output logic                  push,
  output emit_cmd_t             push_cmd
);

  localparam int WIN_DEPTH = (MAX_PATTERN < REG_CHARS) ? MAX_PATTERN : REG_CHARS;
  localparam int RPL_MAX   = (MAX_REPLACEMENT < REG_CHARS) ? MAX_REPLACEMENT : REG_CHARS;
  localparam logic [CNT_W-1:0] WIN_MAX_C = CNT_W'(WIN_DEPTH);
  localparam logic [CNT_W-1:0] RPL_MAX_C = CNT_W'(RPL_MAX);

  logic [3:0]                  plen_r;
  logic [3:0]                  rlen_r;
  byte_vec_t                   pat_r;
  byte_vec_t                   rpl_r;
  logic [WIN_DEPTH-1:0][7:0]   win_r, win_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;

  logic [CNT_W-1:0] len, rlen, idx, nc;
  byte_vec_t        nw, shifted;
  logic             match;
  logic             accept;
  emit_cmd_t        cmd;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    len  = (CNT_W'(plen_r) > WIN_MAX_C) ? WIN_MAX_C : CNT_W'(plen_r);
    rlen = (CNT_W'(rlen_r) > RPL_MAX_C) ? RPL_MAX_C : CNT_W'(rlen_r);
    idx  = (cnt_r >= len) ? '0 : cnt_r;
    nc   = idx + 1'b1;
    nw   = '0;
    nw[WIN_DEPTH-1:0] = win_r;
    nw[idx[IDX_W-1:0]] = in_data_byte;
    shifted = nw >> 8;
    match = 1'b1;
    for (int i = 0; i < WIN_DEPTH; i++) begin
      if (CNT_W'(i) < len && nw[i] != pat_r[i]) match = 1'b0;
    end

    cmd.bytes = nw;
    cmd.count = '0;
    cnt_nxt   = cnt_r;
    win_nxt   = win_r;
    if (len == '0) begin
      cmd.count = CNT_W'(1);
      cnt_nxt   = '0;
    end else if (in_data_byte == NEWLINE_CHAR) begin
      cmd.count = nc;
      cnt_nxt   = '0;
    end else begin
      win_nxt = nw[WIN_DEPTH-1:0];
      cnt_nxt = nc;
      if (nc == len) begin
        if (match) begin
          cmd.bytes = rpl_r;
          cmd.count = rlen;
          cnt_nxt   = '0;
        end else if (in_stream_end) begin
          cmd.count = len;
          cnt_nxt   = '0;
        end else begin
          cmd.count = CNT_W'(1);
          win_nxt   = shifted[WIN_DEPTH-1:0];
          cnt_nxt   = len - 1'b1;
        end
      end else if (in_stream_end) begin
        cmd.count = nc;
        cnt_nxt   = '0;
      end
    end
  end

  assign push     = accept && (cmd.count != '0);
  assign push_cmd = cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plen_r <= '0;
      rlen_r <= '0;
      pat_r  <= '0;
      rpl_r  <= '0;
      cnt_r  <= '0;
    end else begin
      if (accept) begin
        cnt_r <= cnt_nxt;
      end
      if (cfg_wr_en) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_PATTERN_LENGTH: begin
            plen_r <= cfg_data[3:0];
            cnt_r  <= '0;
          end
          REG_PATTERN_BYTES:      pat_r  <= byte_vec_t'(cfg_data);
          REG_REPLACEMENT_LENGTH: rlen_r <= cfg_data[3:0];
          REG_REPLACEMENT_BYTES:  rpl_r  <= byte_vec_t'(cfg_data);
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      win_r <= win_nxt;
    end
  end

  a_cnt_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    (len != '0) |-> (cnt_r < len))
    else $error("window count reached pattern length");

endmodule

[rtl/sfr_queue.sv]
// sfr_queue: short command queue between classification and emission.
// Depends on sfr_pkg.
module sfr_queue import sfr_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  emit_cmd_t push_cmd,
  output logic      full,
  input  logic      pop,
  output logic      head_valid,
  output emit_cmd_t head_cmd
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int QC_W  = $clog2(DEPTH + 1);

  emit_cmd_t        mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QC_W-1:0]  count_r;

  assign full       = (count_r == QC_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("pop from empty queue");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QC_W'(DEPTH))
    else $error("queue count out of range");

endmodule

[rtl/sfr_back.sv]
// sfr_back: serializes emit commands into output bytes, one per cycle when
// not stalled, marking the last byte of each command. Depends on sfr_pkg.
module sfr_back import sfr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  emit_cmd_t  q_cmd,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_out_byte,
  output logic       out_run_last
);

  byte_vec_t        bytes_r;
  logic [CNT_W-1:0] rem_r;
  logic             out_accept;

  assign out_valid    = (rem_r != '0);
  assign out_accept   = out_valid && !out_stall;
  assign out_out_byte = bytes_r[0];
  assign out_run_last = (rem_r == CNT_W'(1));
  assign pop          = q_valid && ((rem_r == '0) || (out_accept && out_run_last));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
    end else if (pop) begin
      rem_r <= q_cmd.count;
    end else if (out_accept) begin
      rem_r <= rem_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      bytes_r <= q_cmd.bytes;
    end else if (out_accept) begin
      bytes_r <= bytes_r >> 8;
    end
  end

  a_queued_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid |-> (q_cmd.count != '0))
    else $error("empty command in queue");

  a_load_when_done: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (rem_r == '0 || rem_r == CNT_W'(1)))
    else $error("command loaded over unfinished one");

endmodule

[rtl/stream_find_replace.sv]
// stream_find_replace: top level, front classifier, command queue and
// byte emitter. Depends on sfr_pkg, sfr_front, sfr_queue, sfr_back.
//
// Replaces each leftmost, non-overlapping occurrence of a pattern of up to
// eight bytes with a replacement of zero to eight bytes; newline or the
// stream end flushes held bytes. One input byte is taken per clock while
// the two-entry command queue has room. Each byte yields at most one
// command, of 1..8 output bytes; the emitter sends one output byte per
// clock while out_stall is low, and input is stalled only when the queue
// backs up behind the emitter. Input reaches the first output byte through
// a queue entry and then the emitter's byte register.
module stream_find_replace import sfr_pkg::*; #(
  parameter int MAX_PATTERN     = MAX_PATTERN_DEF,
  parameter int MAX_REPLACEMENT = MAX_REPLACEMENT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_data_byte,
  input  logic                  in_stream_end,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_out_byte,
  output logic                  out_run_last
);

  logic      q_full, q_push, q_pop, q_valid;
  emit_cmd_t push_cmd, head_cmd;

  sfr_front #(
    .MAX_PATTERN     (MAX_PATTERN),
    .MAX_REPLACEMENT (MAX_REPLACEMENT)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data_byte  (in_data_byte),
    .in_stream_end (in_stream_end),
    .q_full        (q_full),
    .push          (q_push),
    .push_cmd      (push_cmd)
  );

  sfr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (head_cmd)
  );

  sfr_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_cmd        (head_cmd),
    .pop          (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_out_byte (out_out_byte),
    .out_run_last (out_run_last)
  );

endmodule
